// ===== rtl/core/cba_pkg.sv =====
// cba_pkg: shared types and constants of the cluster bitmap allocator
// field widths, request codes, sequencer states and the bit-search result type
// no dependencies
`default_nettype none

package cba_pkg;

  // payload field widths
  localparam int unsigned OP_W      = 2;
  localparam int unsigned CLUSTER_W = 12;
  localparam int unsigned TOTAL_W   = 13;

  // bitmap word organisation
  localparam int unsigned WORD_W = 64;
  localparam int unsigned BIT_W  = 6;

  // request codes
  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_USE   = 2'd1,
    OP_FREE  = 2'd2,
    OP_QUERY = 2'd3
  } op_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR  = 3'd0,
    ST_IDLE   = 3'd1,
    ST_SCAN   = 3'd2,
    ST_READ   = 3'd3,
    ST_UPDATE = 3'd4,
    ST_DONE   = 3'd5
  } state_e;

  // result of the lowest-set-bit search over one word
  typedef struct packed {
    logic             hit;
    logic [BIT_W-1:0] idx;
  } ffs_t;

endpackage

`default_nettype wire

// ===== rtl/core/cba_if.sv =====
// cba_if: request and response channel interfaces of the cluster bitmap allocator
// valid/ready handshake with payload; depends on cba_pkg
`default_nettype none

interface cba_req_if;
  logic                           valid;
  logic                           ready;
  logic [cba_pkg::OP_W-1:0]       op;
  logic [cba_pkg::CLUSTER_W-1:0]  cluster;

  modport source (output valid, output op, output cluster, input ready);
  modport sink   (input valid, input op, input cluster, output ready);
endinterface

interface cba_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [cba_pkg::CLUSTER_W-1:0]  result_cluster;
  logic                           found;
  logic                           cluster_free;
  logic [cba_pkg::TOTAL_W-1:0]    free_total;
  logic [cba_pkg::TOTAL_W-1:0]    used_total;

  modport source (output valid, output result_cluster, output found,
                  output cluster_free, output free_total, output used_total,
                  input ready);
  modport sink   (input valid, input result_cluster, input found,
                  input cluster_free, input free_total, input used_total,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cba_bitmap_ram.sv =====
// cba_bitmap_ram: one-write one-read word memory holding the free bitmap
// read data registered; depends on cba_pkg
`default_nettype none

module cba_bitmap_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [AW-1:0]              waddr_i,
  input  wire logic [cba_pkg::WORD_W-1:0] wdata_i,
  input  wire logic                       re_i,
  input  wire logic [AW-1:0]              raddr_i,
  output logic      [cba_pkg::WORD_W-1:0] rdata_o
);

  logic [cba_pkg::WORD_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cba_find_first.sv =====
// cba_find_first: lowest set bit search over one bitmap word
// isolates the lowest one with a two's complement and encodes its position; depends on cba_pkg
`default_nettype none

module cba_find_first (
  input  wire logic [cba_pkg::WORD_W-1:0] word_i,
  output cba_pkg::ffs_t                   res_o
);

  logic [cba_pkg::WORD_W-1:0] lowest;
  logic [cba_pkg::WORD_W-1:0] sel;

  // keep only the lowest set bit
  assign lowest = word_i & (~word_i + cba_pkg::WORD_W'(1));

  // encode the one-hot position, one index bit at a time
  always_comb begin
    res_o.hit = |word_i;
    for (int j = 0; j < cba_pkg::BIT_W; j++) begin
      for (int p = 0; p < cba_pkg::WORD_W; p++) begin
        sel[p] = lowest[p] & ((p >> j) & 1) == 1;
      end
      res_o.idx[j] = |sel;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cluster_bitmap_allocator.sv =====
// cluster_bitmap_allocator: free/used bitmap over storage clusters with lowest-free allocation
// top level: sequencer, counters and output register; depends on cba_pkg, cba_if,
// cba_bitmap_ram and cba_find_first
//
// Usage: requests arrive on req_i (op, cluster), one response per request leaves on
// rsp_o. The bitmap lives in a memory of 64-bit words, NUM_WORDS = ceil(NUM_CLUSTERS/64).
// Allocation reads one word per cycle through the single read port and checks each
// word with a shared lowest-set-bit unit, so op 0 stops at the first word with a
// free cluster and ends sooner when one sits early. Mark used, free and query do one
// memory read and one update; a cluster outside the map goes straight to the
// response. One request is worked on at a time; req_i.ready is high only while the
// sequencer is idle, so the next request is taken in the cycle after the previous
// response is loaded, at the earliest.
// After reset the block sweeps the memory once, writing one word per cycle, and
// accepts no request until the sweep ends; clusters 0 and 1 start used.
// The response is held in an output register: while rsp_o is stalled the block still
// takes the next request and works on it, and finishes only when the register frees.
`default_nettype none

module cluster_bitmap_allocator #(
  parameter int unsigned NUM_CLUSTERS = 4096
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cba_req_if.sink    req_i,
  cba_rsp_if.source  rsp_o
);

  localparam int unsigned WORD_W    = cba_pkg::WORD_W;
  localparam int unsigned BIT_W     = cba_pkg::BIT_W;
  localparam int unsigned NUM_WORDS = (NUM_CLUSTERS + WORD_W - 1) / WORD_W;
  localparam int unsigned WA        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned IDX_W     = WA + BIT_W;
  localparam int unsigned CNT_W     = $clog2(NUM_CLUSTERS + 1);
  localparam int unsigned REM       = NUM_CLUSTERS % WORD_W;
  localparam logic [WORD_W-1:0] LAST_MASK =
    (REM == 0) ? {WORD_W{1'b1}} : ((WORD_W'(1) << REM) - WORD_W'(1));
  localparam logic [WORD_W-1:0] FIRST_MASK = ~WORD_W'(3);

  // sequencer and working registers
  cba_pkg::state_e                 state_q, state_d;
  logic [cba_pkg::OP_W-1:0]        op_q, op_d;
  logic [cba_pkg::CLUSTER_W-1:0]   cl_q, cl_d;
  logic [WA:0]                     scan_addr_q, scan_addr_d;
  logic [WA-1:0]                   eval_addr_q, eval_addr_d;
  logic                            rd_pend_q, rd_pend_d;
  logic [CNT_W-1:0]                free_count_q, free_count_d;

  // staged result
  logic [cba_pkg::CLUSTER_W-1:0]   res_cl_q, res_cl_d;
  logic                            res_found_q, res_found_d;
  logic                            res_free_q, res_free_d;

  // output register
  logic                            out_valid_q, out_valid_d;
  logic [cba_pkg::CLUSTER_W-1:0]   out_cl_q, out_cl_d;
  logic                            out_found_q, out_found_d;
  logic                            out_free_q, out_free_d;
  logic [cba_pkg::TOTAL_W-1:0]     out_ftot_q, out_ftot_d;
  logic [cba_pkg::TOTAL_W-1:0]     out_utot_q, out_utot_d;

  // memory and search unit signals
  logic                ram_we, ram_re;
  logic [WA-1:0]       ram_waddr, ram_raddr;
  logic [WORD_W-1:0]   ram_wdata, ram_rdata;
  logic [WORD_W-1:0]   init_word;
  cba_pkg::ffs_t       ffs;

  logic [IDX_W-1:0]    cl_ext;
  logic [WA-1:0]       cl_word;
  logic [BIT_W-1:0]    cl_bit;
  logic [WORD_W-1:0]   cl_mask;
  logic                cl_was_free;
  logic                req_in_map;
  logic [CNT_W-1:0]    used_count;

  cba_bitmap_ram #(
    .DEPTH (NUM_WORDS),
    .AW    (WA)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  cba_find_first u_ffs (
    .word_i (ram_rdata),
    .res_o  (ffs)
  );

  // split of the held cluster number into word and bit
  assign cl_ext      = IDX_W'(cl_q);
  assign cl_word     = cl_ext[IDX_W-1:BIT_W];
  assign cl_bit      = cl_ext[BIT_W-1:0];
  assign cl_mask     = WORD_W'(1) << cl_bit;
  assign cl_was_free = |(ram_rdata & cl_mask);
  assign req_in_map  = 32'(req_i.cluster) < 32'(NUM_CLUSTERS);
  assign used_count  = CNT_W'(NUM_CLUSTERS) - free_count_d;

  // reset contents of the word under the clearing sweep
  always_comb begin
    init_word = {WORD_W{1'b1}};
    if (scan_addr_q[WA-1:0] == WA'(NUM_WORDS - 1)) begin
      init_word = init_word & LAST_MASK;
    end
    if (scan_addr_q[WA-1:0] == '0) begin
      init_word = init_word & FIRST_MASK;
    end
  end

  // sequencer: next state, memory control and result staging
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    cl_d         = cl_q;
    scan_addr_d  = scan_addr_q;
    eval_addr_d  = eval_addr_q;
    rd_pend_d    = rd_pend_q;
    free_count_d = free_count_q;
    res_cl_d     = res_cl_q;
    res_found_d  = res_found_q;
    res_free_d   = res_free_q;
    ram_we       = 1'b0;
    ram_waddr    = eval_addr_q;
    ram_wdata    = ram_rdata;
    ram_re       = 1'b0;
    ram_raddr    = scan_addr_q[WA-1:0];
    req_i.ready  = 1'b0;
    out_valid_d  = out_valid_q & ~rsp_o.ready;
    out_cl_d     = out_cl_q;
    out_found_d  = out_found_q;
    out_free_d   = out_free_q;
    out_ftot_d   = out_ftot_q;
    out_utot_d   = out_utot_q;

    case (state_q)
      cba_pkg::ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = scan_addr_q[WA-1:0];
        ram_wdata   = init_word;
        scan_addr_d = scan_addr_q + (WA+1)'(1);
        if (scan_addr_q == (WA+1)'(NUM_WORDS - 1)) begin
          scan_addr_d = '0;
          state_d     = cba_pkg::ST_IDLE;
        end
      end

      cba_pkg::ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          op_d = req_i.op;
          cl_d = req_i.cluster;
          if (req_i.op == cba_pkg::OP_ALLOC) begin
            scan_addr_d = '0;
            rd_pend_d   = 1'b0;
            state_d     = cba_pkg::ST_SCAN;
          end else if (req_in_map) begin
            state_d = cba_pkg::ST_READ;
          end else begin
            // cluster beyond the map: nothing changes
            res_cl_d    = req_i.cluster;
            res_found_d = 1'b0;
            res_free_d  = 1'b0;
            state_d     = cba_pkg::ST_DONE;
          end
        end
      end

      cba_pkg::ST_SCAN: begin
        if (rd_pend_q && ffs.hit) begin
          // lowest free cluster found: mark it used
          ram_we       = 1'b1;
          ram_waddr    = eval_addr_q;
          ram_wdata    = ram_rdata & ~(WORD_W'(1) << ffs.idx);
          free_count_d = free_count_q - CNT_W'(1);
          res_cl_d     = cba_pkg::CLUSTER_W'({eval_addr_q, ffs.idx});
          res_found_d  = 1'b1;
          res_free_d   = 1'b0;
          state_d      = cba_pkg::ST_DONE;
        end else if (scan_addr_q < (WA+1)'(NUM_WORDS)) begin
          ram_re      = 1'b1;
          ram_raddr   = scan_addr_q[WA-1:0];
          eval_addr_d = scan_addr_q[WA-1:0];
          scan_addr_d = scan_addr_q + (WA+1)'(1);
          rd_pend_d   = 1'b1;
        end else begin
          rd_pend_d = 1'b0;
          if (!rd_pend_q) begin
            // map full
            res_cl_d    = '0;
            res_found_d = 1'b0;
            res_free_d  = 1'b0;
            state_d     = cba_pkg::ST_DONE;
          end
        end
      end

      cba_pkg::ST_READ: begin
        ram_re    = 1'b1;
        ram_raddr = cl_word;
        state_d   = cba_pkg::ST_UPDATE;
      end

      cba_pkg::ST_UPDATE: begin
        res_cl_d    = cl_q;
        res_found_d = 1'b0;
        res_free_d  = cl_was_free;
        ram_waddr   = cl_word;
        if (op_q == cba_pkg::OP_USE && cl_was_free) begin
          ram_we       = 1'b1;
          ram_wdata    = ram_rdata & ~cl_mask;
          free_count_d = free_count_q - CNT_W'(1);
          res_free_d   = 1'b0;
        end else if (op_q == cba_pkg::OP_FREE && !cl_was_free) begin
          ram_we       = 1'b1;
          ram_wdata    = ram_rdata | cl_mask;
          free_count_d = free_count_q + CNT_W'(1);
          res_free_d   = 1'b1;
        end
        state_d = cba_pkg::ST_DONE;
      end

      cba_pkg::ST_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_cl_d    = res_cl_q;
          out_found_d = res_found_q;
          out_free_d  = res_free_q;
          out_ftot_d  = cba_pkg::TOTAL_W'(free_count_q);
          out_utot_d  = cba_pkg::TOTAL_W'(CNT_W'(NUM_CLUSTERS) - free_count_q);
          state_d     = cba_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = cba_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= cba_pkg::ST_CLEAR;
      scan_addr_q  <= '0;
      rd_pend_q    <= 1'b0;
      free_count_q <= CNT_W'(NUM_CLUSTERS - 2);
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      scan_addr_q  <= scan_addr_d;
      rd_pend_q    <= rd_pend_d;
      free_count_q <= free_count_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    cl_q        <= cl_d;
    eval_addr_q <= eval_addr_d;
    res_cl_q    <= res_cl_d;
    res_found_q <= res_found_d;
    res_free_q  <= res_free_d;
    out_cl_q    <= out_cl_d;
    out_found_q <= out_found_d;
    out_free_q  <= out_free_d;
    out_ftot_q  <= out_ftot_d;
    out_utot_q  <= out_utot_d;
  end

  // response channel
  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.result_cluster = out_cl_q;
  assign rsp_o.found          = out_found_q;
  assign rsp_o.cluster_free   = out_free_q;
  assign rsp_o.free_total     = out_ftot_q;
  assign rsp_o.used_total     = out_utot_q;

  // no request is taken during the clearing sweep
  a_no_req_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cba_pkg::ST_CLEAR) |-> !req_i.ready)
    else $error("request ready during clearing sweep");

  // the free count never exceeds the map size
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_count_q <= CNT_W'(NUM_CLUSTERS))
    else $error("free count beyond map size");

  // the free count moves by one at most per transaction
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_count_q != $past(free_count_q)) |->
      (free_count_q == $past(free_count_q) + CNT_W'(1) ||
       free_count_q == $past(free_count_q) - CNT_W'(1)))
    else $error("free count jumped");

  // an allocated cluster is never reported free
  a_found_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.found) |-> !rsp_o.cluster_free)
    else $error("allocated cluster reported free");

  // used total plus free total equals the map size at every response
  a_totals: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> ((rsp_o.free_total + rsp_o.used_total) ==
                     cba_pkg::TOTAL_W'(NUM_CLUSTERS)))
    else $error("free and used totals disagree");

  // the used count is only a view of the free count
  a_used_view: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cba_pkg::ST_IDLE) |-> (used_count == CNT_W'(NUM_CLUSTERS) - free_count_q))
    else $error("used count mismatch");

endmodule

`default_nettype wire
